@@ hdl/stq_pkg.sv @@
// Shared types and constants for the sorted timer queue.
package stq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int DUR_BITS    = 40;
  localparam int HANDLE_BITS = 16;
  localparam int ACTION_BITS = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  localparam logic [1:0] KIND_START_ACK = 2'd0;
  localparam logic [1:0] KIND_FIRED     = 2'd1;
  localparam logic [1:0] KIND_NONE_DUE  = 2'd2;

  typedef struct packed {
    logic                   command;
    logic [TIME_BITS-1:0]   now_us;
    logic [DUR_BITS-1:0]    delay_us;
    logic [HANDLE_BITS-1:0] handle;
    logic [ACTION_BITS-1:0] action_id;
  } stq_in_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [HANDLE_BITS-1:0] fired_handle;
    logic [ACTION_BITS-1:0] fired_action;
    logic                   new_head;
    logic                   table_full;
    logic                   has_next;
    logic [TIME_BITS-1:0]   next_expiry_us;
    logic                   last;
  } stq_out_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   expiry;
    logic [HANDLE_BITS-1:0] handle;
    logic [ACTION_BITS-1:0] action;
  } stq_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic scan_adv;
    logic insert;
    logic reject;
    logic pop;
    logic none_due;
  } stq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic scan_stop;
    logic head_due;
    logic pop_last;
  } stq_stat_t;

endpackage

@@ hdl/stq_ctrl.sv @@
// Controller state machine of the sorted timer queue.
module stq_ctrl import stq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      req_command,
  input  stq_stat_t stat,
  output stq_cmd_t  cmd,
  output logic      busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_PROC = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = (req_command == CMD_PROCESS) ? ST_PROC : ST_CALC;
        end
      end
      ST_CALC: begin
        // form expiry; drop at once when no entry is free
        if (stat.full) begin
          cmd.reject = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.calc  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_stop) begin
          cmd.insert = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_PROC: begin
        if (stat.head_due) begin
          cmd.pop = 1'b1;
          if (stat.pop_last) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.none_due = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ hdl/stq_datapath.sv @@
// Datapath of the sorted timer queue: entry table, scan index, result register.
module stq_datapath import stq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  stq_in_t   in_req,
  input  stq_cmd_t  cmd,
  output stq_stat_t stat,
  output logic      out_strobe,
  output stq_out_t  out_res
);

  stq_in_t                req_r;
  stq_entry_t             entry_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]       count_r;
  logic [IDX_W-1:0]       idx_r;
  logic [TIME_BITS-1:0]   exp_r;
  logic                   out_strobe_r;
  stq_out_t               out_res_r;
  stq_out_t               out_res_nxt;

  logic [TIME_BITS:0]     sum;
  logic [TIME_BITS-1:0]   exp_sat;
  stq_entry_t             scan_entry;
  stq_entry_t             new_entry;
  logic                   head_le;
  logic                   second_le;

  // saturating expiry
  assign sum     = (TIME_BITS+1)'(req_r.now_us) + (TIME_BITS+1)'(req_r.delay_us);
  assign exp_sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

  assign scan_entry = entry_r[idx_r];
  assign new_entry  = '{expiry: exp_r, handle: req_r.handle, action: req_r.action_id};
  assign head_le    = (entry_r[0].expiry <= req_r.now_us);
  assign second_le  = (entry_r[1].expiry <= req_r.now_us);

  assign stat.full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.scan_stop = (CNT_W'(idx_r) == count_r) || (exp_r < scan_entry.expiry);
  assign stat.head_due  = (count_r != '0) && head_le;
  assign stat.pop_last  = (count_r == CNT_W'(1)) || !second_le;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
    if (cmd.calc) begin
      exp_r <= exp_sat;
    end
    if (cmd.calc) begin
      idx_r <= '0;
    end else if (cmd.scan_adv) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // entry table: insert shifts the tail up, pop shifts everything down
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (IDX_W'(g) == idx_r) begin
          entry_r[g] <= new_entry;
        end else if (g > 0 && IDX_W'(g) > idx_r && CNT_W'(g) <= count_r) begin
          entry_r[g] <= entry_r[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd.pop) begin
        if (g < QUEUE_DEPTH - 1) begin
          entry_r[g] <= entry_r[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.insert) begin
      count_r <= count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.insert | cmd.reject | cmd.pop | cmd.none_due;
    end
  end

  always_comb begin
    out_res_nxt = '0;
    if (cmd.insert) begin
      out_res_nxt.kind     = KIND_START_ACK;
      out_res_nxt.new_head = (idx_r == '0);
      out_res_nxt.last     = 1'b1;
    end else if (cmd.reject) begin
      out_res_nxt.kind       = KIND_START_ACK;
      out_res_nxt.table_full = 1'b1;
      out_res_nxt.last       = 1'b1;
    end else if (cmd.pop) begin
      out_res_nxt.kind         = KIND_FIRED;
      out_res_nxt.fired_handle = entry_r[0].handle;
      out_res_nxt.fired_action = entry_r[0].action;
      out_res_nxt.last         = stat.pop_last;
      if (stat.pop_last && count_r >= CNT_W'(2)) begin
        out_res_nxt.has_next       = 1'b1;
        out_res_nxt.next_expiry_us = entry_r[1].expiry;
      end
    end else if (cmd.none_due) begin
      out_res_nxt.kind = KIND_NONE_DUE;
      out_res_nxt.last = 1'b1;
      if (count_r != '0) begin
        out_res_nxt.has_next       = 1'b1;
        out_res_nxt.next_expiry_us = entry_r[0].expiry;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

@@ hdl/sorted_timer_queue_core.sv @@
// Top level of the sorted timer queue: controller plus datapath.
//
// Keeps up to QUEUE_DEPTH one-shot timers sorted by expiry (microseconds).
// A request is taken at a rising edge where start is high and busy is low.
// A start request (command 0) sets expiry = now_us + delay_us, saturating
// at all ones, and places the timer after every entry with an equal or
// earlier expiry; it yields one result with new_head, or with table_full
// when no entry is free (the timer is then dropped). A process request
// (command 1) pops every timer whose expiry is at or before now_us, one
// fired result per timer in expiry order, or one "none due" result when
// nothing has expired; the final result carries last, has_next and
// next_expiry_us. Every result sits on out_res for exactly one cycle,
// flagged by out_strobe, and cannot be held off, so capture it on sight.
// Busy stays high on a start through the expiry step, one scan step per
// pending timer expiring at or before the new one (one table entry is
// compared per cycle) and the insert step, or the expiry step if rejected;
// on a process request through one pop step per popped timer, one pop per
// cycle, or one none-due step. Each result is registered and shows in the
// cycle after its step, so fired results stream one per cycle while busy
// is high, and the final result of every request sits on the ports in the
// first cycle with busy low; a new request may be given in that same cycle.
module sorted_timer_queue_core import stq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  stq_in_t  in_req,
  output logic     out_strobe,
  output stq_out_t out_res
);

  stq_cmd_t  cmd;
  stq_stat_t stat;

  // sequence scan, insert and pop steps
  stq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .req_command (in_req.command),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  // hold the table and drive the result register
  stq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
